// ----- hw/rtl/hmt_pkg.sv -----
// Shared constants, codes and types for the HTML markup tokenizer.
package hmt_pkg;

   localparam int UNIT_BITS   = 16;
   localparam int STACK_DEPTH = 1024;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int STEP_CHAIN  = 6;

   typedef logic [UNIT_BITS-1:0] unit_type;
   typedef logic [2:0]           role_type;
   typedef logic [2:0]           bracket_type;

   // Result roles
   localparam role_type ROLE_MARKUP = 3'd0;
   localparam role_type ROLE_COMMENT = 3'd1;
   localparam role_type ROLE_TAG    = 3'd2;
   localparam role_type ROLE_KEY    = 3'd3;
   localparam role_type ROLE_VALUE  = 3'd4;
   localparam role_type ROLE_TEXT   = 3'd5;
   localparam role_type ROLE_SCRIPT = 3'd6;
   localparam role_type ROLE_STYLE  = 3'd7;

   // Bracket stack codes
   localparam bracket_type BR_NONE   = 3'd0;
   localparam bracket_type BR_BRACE  = 3'd1;
   localparam bracket_type BR_PAREN  = 3'd2;
   localparam bracket_type BR_SQUARE = 3'd3;
   localparam bracket_type BR_SQUOTE = 3'd4;
   localparam bracket_type BR_DQUOTE = 3'd5;

   // Tag name prefix matching
   localparam logic [2:0] SCRIPT_LEN  = 3'd6;
   localparam logic [2:0] STYLE_LEN   = 3'd5;
   localparam logic [2:0] PREFIX_MISS = 3'd7;

   // Characters
   localparam unit_type CH_NUL    = UNIT_BITS'(8'h00);
   localparam unit_type CH_TAB    = UNIT_BITS'(8'h09);
   localparam unit_type CH_LF     = UNIT_BITS'(8'h0A);
   localparam unit_type CH_CR     = UNIT_BITS'(8'h0D);
   localparam unit_type CH_SPACE  = UNIT_BITS'(8'h20);
   localparam unit_type CH_BANG   = UNIT_BITS'(8'h21);
   localparam unit_type CH_DQUOTE = UNIT_BITS'(8'h22);
   localparam unit_type CH_SQUOTE = UNIT_BITS'(8'h27);
   localparam unit_type CH_LPAREN = UNIT_BITS'(8'h28);
   localparam unit_type CH_RPAREN = UNIT_BITS'(8'h29);
   localparam unit_type CH_STAR   = UNIT_BITS'(8'h2A);
   localparam unit_type CH_DASH   = UNIT_BITS'(8'h2D);
   localparam unit_type CH_SLASH  = UNIT_BITS'(8'h2F);
   localparam unit_type CH_LT     = UNIT_BITS'(8'h3C);
   localparam unit_type CH_EQ     = UNIT_BITS'(8'h3D);
   localparam unit_type CH_GT     = UNIT_BITS'(8'h3E);
   localparam unit_type CH_UPPER_A = UNIT_BITS'(8'h41);
   localparam unit_type CH_UPPER_Z = UNIT_BITS'(8'h5A);
   localparam unit_type CH_LSQUARE = UNIT_BITS'(8'h5B);
   localparam unit_type CH_BSLASH = UNIT_BITS'(8'h5C);
   localparam unit_type CH_RSQUARE = UNIT_BITS'(8'h5D);
   localparam unit_type CH_LBRACE = UNIT_BITS'(8'h7B);
   localparam unit_type CH_RBRACE = UNIT_BITS'(8'h7D);
   localparam unit_type CASE_GAP  = UNIT_BITS'(8'h20);

   // Stack command from the classifier and status back to it
   typedef struct packed {
      logic        clear;
      logic        push;
      logic        pop;
      bracket_type code;
   } stk_cmd_type;

   typedef struct packed {
      logic        empty;
      logic        full;
      bracket_type top;
   } stk_status_type;

endpackage

// ----- hw/rtl/hmt_req_if.sv -----
// Input channel: one code unit per transaction.
interface hmt_req_if;
   logic                      valid;
   logic                      ready;
   logic [hmt_pkg::UNIT_BITS-1:0] code_unit;
   logic                      end_of_document;

   modport source (output valid, output code_unit, output end_of_document, input ready);
   modport sink   (input valid, input code_unit, input end_of_document, output ready);
endinterface

// ----- hw/rtl/hmt_rsp_if.sv -----
// Result channel: one classified code unit per transaction.
interface hmt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [hmt_pkg::UNIT_BITS-1:0] out_unit;
   logic [2:0]                role;
   logic                      token_start;
   logic                      last;

   modport source (output valid, output out_unit, output role, output token_start,
                   output last, input ready);
   modport sink   (input valid, input out_unit, input role, input token_start,
                   input last, output ready);
endinterface

// ----- hw/rtl/hmt_stack.sv -----
// Bracket and quote stack: memory with registered top and next-below entries.
module hmt_stack (
   input  logic                    clock,
   input  logic                    reset,
   input  hmt_pkg::stk_cmd_type    cmd,
   output hmt_pkg::stk_status_type status
);

   hmt_pkg::bracket_type mem [hmt_pkg::STACK_DEPTH];

   logic [hmt_pkg::SP_W-1:0]   sp_ff, sp_in, sp_base, sp_rd;
   logic [hmt_pkg::STK_AW-1:0] rd_addr, wr_addr;
   hmt_pkg::bracket_type       top_ff, top_in, below_ff;

   // Apply clear first, then the push or pop
   always_comb begin
      sp_base = cmd.clear ? '0 : sp_ff;
      sp_in   = sp_base;
      top_in  = top_ff;
      if (cmd.push) begin
         sp_in  = sp_base + hmt_pkg::SP_W'(1);
         top_in = cmd.code;
      end else if (cmd.pop) begin
         sp_in  = sp_base - hmt_pkg::SP_W'(1);
         top_in = below_ff;
      end
      sp_rd   = sp_in - hmt_pkg::SP_W'(2);
      rd_addr = sp_rd[hmt_pkg::STK_AW-1:0];
      wr_addr = sp_base[hmt_pkg::STK_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
      top_ff <= top_in;
   end

   // Write the pushed code; keep the entry under the top ready for a pop
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= cmd.code;
      end
      below_ff <= mem[rd_addr];
   end

   always_comb begin
      status.empty = (sp_ff == '0);
      status.full  = (sp_ff == hmt_pkg::SP_W'(hmt_pkg::STACK_DEPTH));
      status.top   = status.empty ? hmt_pkg::BR_NONE : top_ff;
   end

endmodule

// ----- hw/rtl/hmt_classifier.sv -----
// Parse state machine: classifies one code unit per step with one unit of lookahead.
module hmt_classifier (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic                 restart,
   input  hmt_pkg::unit_type    unit,
   input  hmt_pkg::unit_type    la,
   output hmt_pkg::role_type    role,
   output logic                 token_start
);

   typedef enum logic [4:0] {
      M_LEAD, M_TOP, M_ITEM, M_CBANG, M_CDASH1, M_CSHORT, M_CLONG, M_SEEKLT,
      M_TAG, M_ASKIP0, M_ATOP, M_ASKIP, M_KEY, M_AGT, M_VSTART, M_VDQ, M_VSQ,
      M_VBARE, M_TXSKIP, M_TXWORD, M_BSKIP, M_BTOP, M_BLC1, M_BLINE, M_BBC1,
      M_BBLK, M_BBC2, M_BB, M_BESC, M_DONE
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [5:0]           prefix;
      logic [1:0]           dash;
      logic                 first;
      logic                 slash;
      logic                 style;
      logic                 empty;
      logic                 full;
      hmt_pkg::bracket_type top;
      hmt_pkg::role_type    role;
      logic                 start;
      logic                 again;
      logic                 push;
      logic                 pop;
      logic                 clear;
      hmt_pkg::bracket_type code;
   } ctx_type;

   mode_type   mode_ff;
   logic [5:0] prefix_ff;
   logic [1:0] dash_ff;
   logic       first_ff, slash_ff, style_ff;

   hmt_pkg::stk_cmd_type    stk_cmd;
   hmt_pkg::stk_status_type stk_status;
   ctx_type                 ctx;

   function automatic logic is_space(hmt_pkg::unit_type c);
      return c == hmt_pkg::CH_SPACE || c == hmt_pkg::CH_CR ||
             c == hmt_pkg::CH_LF || c == hmt_pkg::CH_TAB;
   endfunction

   function automatic hmt_pkg::unit_type fold(hmt_pkg::unit_type c);
      if (c >= hmt_pkg::CH_UPPER_A && c <= hmt_pkg::CH_UPPER_Z) return c + hmt_pkg::CASE_GAP;
      return c;
   endfunction

   function automatic logic [7:0] word_char(logic is_style, logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (is_style) begin
         case (idx)
            3'd0:    ch = "s";
            3'd1:    ch = "t";
            3'd2:    ch = "y";
            3'd3:    ch = "l";
            3'd4:    ch = "e";
            default: ch = 8'h00;
         endcase
      end else begin
         case (idx)
            3'd0:    ch = "s";
            3'd1:    ch = "c";
            3'd2:    ch = "r";
            3'd3:    ch = "i";
            3'd4:    ch = "p";
            3'd5:    ch = "t";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

   function automatic logic [2:0] prefix_step(logic [2:0] count, logic is_style,
                                               hmt_pkg::unit_type c);
      logic [2:0] len;
      len = is_style ? hmt_pkg::STYLE_LEN : hmt_pkg::SCRIPT_LEN;
      if (count >= len) return count;
      if (fold(c) == hmt_pkg::UNIT_BITS'(word_char(is_style, count))) return count + 3'd1;
      return hmt_pkg::PREFIX_MISS;
   endfunction

   function automatic hmt_pkg::bracket_type opener(hmt_pkg::unit_type c);
      if (c == hmt_pkg::CH_LBRACE)  return hmt_pkg::BR_BRACE;
      if (c == hmt_pkg::CH_LPAREN)  return hmt_pkg::BR_PAREN;
      if (c == hmt_pkg::CH_LSQUARE) return hmt_pkg::BR_SQUARE;
      if (c == hmt_pkg::CH_SQUOTE)  return hmt_pkg::BR_SQUOTE;
      if (c == hmt_pkg::CH_DQUOTE)  return hmt_pkg::BR_DQUOTE;
      return hmt_pkg::BR_NONE;
   endfunction

   function automatic logic escapable(hmt_pkg::unit_type c);
      return c == hmt_pkg::CH_BSLASH || c == hmt_pkg::CH_LPAREN ||
             c == hmt_pkg::CH_RPAREN || c == hmt_pkg::CH_LSQUARE ||
             c == hmt_pkg::CH_RSQUARE || c == hmt_pkg::CH_LBRACE ||
             c == hmt_pkg::CH_RBRACE || c == hmt_pkg::CH_SQUOTE ||
             c == hmt_pkg::CH_DQUOTE;
   endfunction

   // Pick script, style or text content from the matched tag prefix
   function automatic ctx_type enter_content(ctx_type s);
      ctx_type r;
      r = s;
      if (s.prefix[2:0] == hmt_pkg::SCRIPT_LEN) begin
         r.style = 1'b0;
         r.mode  = M_BSKIP;
      end else if (s.prefix[5:3] == hmt_pkg::STYLE_LEN) begin
         r.style = 1'b1;
         r.mode  = M_BSKIP;
      end else begin
         r.mode = M_TXSKIP;
      end
      return r;
   endfunction

   // One pass of the parse state machine; again asks for another pass on the same unit
   function automatic ctx_type step(ctx_type s_in, hmt_pkg::unit_type c, hmt_pkg::unit_type n);
      ctx_type              s;
      hmt_pkg::role_type    body_role;
      hmt_pkg::bracket_type code;
      logic                 open;
      s         = s_in;
      s.again   = 1'b0;
      body_role = s.style ? hmt_pkg::ROLE_STYLE : hmt_pkg::ROLE_SCRIPT;
      code      = opener(c);
      open      = (s.top != hmt_pkg::BR_SQUOTE) && (s.top != hmt_pkg::BR_DQUOTE) &&
                  !(s.style && s.top == hmt_pkg::BR_PAREN);
      unique case (s.mode)
         M_LEAD: begin
            if (!is_space(c)) begin
               s.mode  = M_TOP;
               s.again = 1'b1;
            end
         end
         M_TOP: begin
            s.mode  = M_ITEM;
            s.again = (c != hmt_pkg::CH_LT);
         end
         M_ITEM: begin
            if (c == hmt_pkg::CH_BANG) begin
               s.role  = hmt_pkg::ROLE_COMMENT;
               s.start = 1'b1;
               s.mode  = M_CBANG;
            end else begin
               s.prefix = '0;
               s.slash  = (c == hmt_pkg::CH_SLASH);
               s.first  = 1'b1;
               s.mode   = M_TAG;
               s.again  = 1'b1;
            end
         end
         M_CBANG, M_CDASH1: begin
            if (c == hmt_pkg::CH_DASH) begin
               s.role = hmt_pkg::ROLE_COMMENT;
               if (s.mode == M_CBANG) begin
                  s.mode = M_CDASH1;
               end else begin
                  s.mode = M_CLONG;
                  s.dash = 2'd0;
               end
            end else begin
               s.mode  = M_CSHORT;
               s.again = 1'b1;
            end
         end
         M_CSHORT: begin
            if (c == hmt_pkg::CH_GT) s.mode = M_SEEKLT;
            else s.role = hmt_pkg::ROLE_COMMENT;
         end
         M_CLONG: begin
            if (c == hmt_pkg::CH_GT && s.dash == 2'd2) begin
               s.mode = M_SEEKLT;
            end else begin
               s.role = hmt_pkg::ROLE_COMMENT;
               if (c == hmt_pkg::CH_DASH) s.dash = (s.dash == 2'd2) ? 2'd2 : s.dash + 2'd1;
               else s.dash = 2'd0;
            end
         end
         M_SEEKLT: begin
            if (c == hmt_pkg::CH_LT) s.mode = M_ITEM;
         end
         M_TAG: begin
            if (c == hmt_pkg::CH_GT) begin
               s = enter_content(s);
            end else if (is_space(c)) begin
               if (s.slash) s = enter_content(s);
               else s.mode = M_ASKIP0;
            end else begin
               s.prefix = {prefix_step(s.prefix[5:3], 1'b1, c),
                           prefix_step(s.prefix[2:0], 1'b0, c)};
               s.role   = hmt_pkg::ROLE_TAG;
               s.start  = s.start | s.first;
               s.first  = 1'b0;
            end
         end
         M_ASKIP0: begin
            if (!is_space(c)) begin
               s.mode  = M_ATOP;
               s.again = 1'b1;
            end
         end
         M_ATOP: begin
            if (c == hmt_pkg::CH_GT) begin
               s = enter_content(s);
            end else if (c == hmt_pkg::CH_LT) begin
               s.mode = M_ITEM;
            end else begin
               s.mode  = M_ASKIP;
               s.again = !is_space(c);
            end
         end
         M_ASKIP, M_KEY: begin
            if (c == hmt_pkg::CH_EQ) begin
               s.mode = M_VSTART;
            end else if (c == hmt_pkg::CH_GT) begin
               s.mode = M_AGT;
            end else if (s.mode == M_KEY) begin
               s.role = hmt_pkg::ROLE_KEY;
            end else if (!is_space(c)) begin
               s.role  = hmt_pkg::ROLE_KEY;
               s.start = 1'b1;
               s.mode  = M_KEY;
            end
         end
         M_AGT: begin
            s       = enter_content(s);
            s.again = (c != hmt_pkg::CH_GT);
         end
         M_VSTART: begin
            if (c == hmt_pkg::CH_DQUOTE) begin
               s.mode  = M_VDQ;
               s.first = 1'b1;
            end else if (c == hmt_pkg::CH_SQUOTE) begin
               s.mode  = M_VSQ;
               s.first = 1'b1;
            end else if (c == hmt_pkg::CH_SPACE || c == hmt_pkg::CH_GT) begin
               s.mode = M_ATOP;
            end else begin
               s.role  = hmt_pkg::ROLE_VALUE;
               s.start = 1'b1;
               s.mode  = M_VBARE;
            end
         end
         M_VDQ, M_VSQ: begin
            if (c == hmt_pkg::CH_GT || (s.mode == M_VDQ && c == hmt_pkg::CH_DQUOTE) ||
                (s.mode == M_VSQ && c == hmt_pkg::CH_SQUOTE)) begin
               s.mode = M_ATOP;
            end else begin
               s.role  = hmt_pkg::ROLE_VALUE;
               s.start = s.start | s.first;
               s.first = 1'b0;
            end
         end
         M_VBARE: begin
            if (c == hmt_pkg::CH_SPACE || c == hmt_pkg::CH_GT) s.mode = M_ATOP;
            else s.role = hmt_pkg::ROLE_VALUE;
         end
         M_TXSKIP: begin
            if (c == hmt_pkg::CH_LT) begin
               s.mode = M_ITEM;
            end else if (!is_space(c)) begin
               s.role  = hmt_pkg::ROLE_TEXT;
               s.start = 1'b1;
               s.mode  = M_TXWORD;
            end
         end
         M_TXWORD: begin
            if (c == hmt_pkg::CH_LT) s.mode = M_TOP;
            else if (is_space(c)) s.mode = M_SEEKLT;
            else s.role = hmt_pkg::ROLE_TEXT;
         end
         M_BSKIP: begin
            if (c == hmt_pkg::CH_LT) begin
               s.mode = M_ITEM;
            end else if (!is_space(c)) begin
               // Fresh body: empty the stack
               s.clear = 1'b1;
               s.empty = 1'b1;
               s.full  = 1'b0;
               s.top   = hmt_pkg::BR_NONE;
               s.start = 1'b1;
               s.mode  = M_BTOP;
               s.again = 1'b1;
            end
         end
         M_BTOP: begin
            s.role = body_role;
            if (open && c == hmt_pkg::CH_SLASH && !s.style && n == hmt_pkg::CH_SLASH) begin
               s.mode = M_BLC1;
            end else if (open && c == hmt_pkg::CH_SLASH && n == hmt_pkg::CH_STAR) begin
               s.mode = M_BBC1;
            end else begin
               s.mode  = M_BB;
               s.again = 1'b1;
            end
         end
         M_BLC1: begin
            s.role = body_role;
            s.mode = M_BLINE;
         end
         M_BLINE: begin
            s.role = body_role;
            if (c == hmt_pkg::CH_LF) s.mode = M_BB;
         end
         M_BBC1: begin
            s.role = body_role;
            s.mode = M_BBLK;
         end
         M_BBLK: begin
            s.role = body_role;
            if (c == hmt_pkg::CH_STAR && n == hmt_pkg::CH_SLASH) s.mode = M_BBC2;
         end
         M_BBC2, M_BESC: begin
            s.role = body_role;
            s.mode = (s.mode == M_BBC2) ? M_BB : M_BTOP;
         end
         M_BB: begin
            s.role = body_role;
            s.mode = M_BTOP;
            if (!s.style && c == hmt_pkg::CH_BSLASH && escapable(n)) begin
               s.mode = M_BESC;
            end else if (code != hmt_pkg::BR_NONE) begin
               if (s.top != hmt_pkg::BR_SQUOTE && s.top != hmt_pkg::BR_DQUOTE) begin
                  // Drop the push when the stack is full
                  if (!s.full) begin
                     s.push = 1'b1;
                     s.code = code;
                  end
               end else if (s.top == code) begin
                  s.pop = 1'b1;
               end
            end else if ((c == hmt_pkg::CH_RBRACE && s.top == hmt_pkg::BR_BRACE) ||
                         (c == hmt_pkg::CH_RPAREN && s.top == hmt_pkg::BR_PAREN) ||
                         (c == hmt_pkg::CH_RSQUARE && s.top == hmt_pkg::BR_SQUARE)) begin
               s.pop = 1'b1;
            end else if (c == hmt_pkg::CH_LT && s.empty) begin
               s.role = hmt_pkg::ROLE_MARKUP;
               s.mode = M_TOP;
            end
         end
         default: begin
            s.mode = M_DONE;
         end
      endcase
      return s;
   endfunction

   // Run the chained passes for the current unit
   always_comb begin
      ctx        = '0;
      ctx.mode   = (unit == hmt_pkg::CH_NUL) ? M_DONE : mode_ff;
      ctx.prefix = prefix_ff;
      ctx.dash   = dash_ff;
      ctx.first  = first_ff;
      ctx.slash  = slash_ff;
      ctx.style  = style_ff;
      ctx.empty  = stk_status.empty;
      ctx.full   = stk_status.full;
      ctx.top    = stk_status.top;
      ctx.again  = 1'b1;
      for (int i = 0; i < hmt_pkg::STEP_CHAIN; i++) begin
         if (ctx.again) ctx = step(ctx, unit, la);
      end
   end

   assign role        = ctx.role;
   assign token_start = ctx.start && (ctx.role != hmt_pkg::ROLE_MARKUP);

   // Drive the stack only on a step; a restart empties it
   always_comb begin
      stk_cmd = '0;
      if (step_en) begin
         if (restart) begin
            stk_cmd.clear = 1'b1;
         end else begin
            stk_cmd.clear = ctx.clear;
            stk_cmd.push  = ctx.push;
            stk_cmd.pop   = ctx.pop;
            stk_cmd.code  = ctx.code;
         end
      end
   end

   // Hold parse state; advance on a step, return to reset after the document ends
   always_ff @(posedge clock) begin
      if (reset || (step_en && restart)) begin
         mode_ff   <= M_LEAD;
         prefix_ff <= '0;
         dash_ff   <= '0;
         first_ff  <= 1'b0;
         slash_ff  <= 1'b0;
         style_ff  <= 1'b0;
      end else if (step_en) begin
         mode_ff   <= ctx.mode;
         prefix_ff <= ctx.prefix;
         dash_ff   <= ctx.dash;
         first_ff  <= ctx.first;
         slash_ff  <= ctx.slash;
         style_ff  <= ctx.style;
      end
   end

   hmt_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (stk_cmd),
      .status (stk_status)
   );

endmodule

// ----- hw/rtl/html_markup_tokenizer_core.sv -----
// Top level of the HTML markup tokenizer: lookahead window, classifier and result register.
//
//   channel | dir | transaction carries
//   --------+-----+---------------------------------------------------
//   req     | in  | code_unit, end_of_document
//   rsp     | out | out_unit, role, token_start, last
//
// One code unit per cycle while rsp is not stalled: each transaction past the third steps
// the oldest unit into the result register. A transaction with end_of_document set flushes
// the window, giving one result per cycle (up to four); req.ready stays low until the last
// of them is registered. The classifier step sets the rate; it reads only registered stack state.
// Synchronous reset clears the window, parse state and stack pointer; no clearing pass.
// A stalled rsp holds the result register and blocks req once the window is full.
module html_markup_tokenizer_core (
   input  logic     clock,
   input  logic     reset,
   hmt_req_if.sink  req,
   hmt_rsp_if.source rsp
);

   hmt_pkg::unit_type win_ff [4];
   hmt_pkg::unit_type win_in [4];
   logic [2:0]        wcnt_ff, wcnt_in, wcnt_shift;
   logic [1:0]        app_idx;
   logic              flush_ff, flush_in;

   logic              step_avail, slot_free, step_fire, accept, is_last;
   hmt_pkg::unit_type la;
   hmt_pkg::role_type cls_role;
   logic              cls_start;

   logic              rsp_valid_ff;
   hmt_pkg::unit_type rsp_unit_ff;
   hmt_pkg::role_type rsp_role_ff;
   logic              rsp_start_ff, rsp_last_ff;

   // Step when the window is full, or while flushing pending units
   always_comb begin
      step_avail = flush_ff ? (wcnt_ff != 3'd0) : (wcnt_ff == 3'd4);
      slot_free  = !rsp_valid_ff || rsp.ready;
      step_fire  = step_avail && slot_free;
      is_last    = flush_ff && (wcnt_ff == 3'd1);
      la         = (wcnt_ff >= 3'd2) ? win_ff[1] : hmt_pkg::CH_NUL;
      req.ready  = !flush_ff && ((wcnt_ff != 3'd4) || step_fire);
      accept     = req.valid && req.ready;
   end

   // Shift out the classified unit, then append the accepted one
   always_comb begin
      wcnt_shift = step_fire ? wcnt_ff - 3'd1 : wcnt_ff;
      app_idx    = wcnt_shift[1:0];
      for (int i = 0; i < 4; i++) begin
         win_in[i] = win_ff[i];
         if (step_fire && i < 3) win_in[i] = win_ff[i+1];
      end
      if (accept) win_in[app_idx] = req.code_unit;
      wcnt_in  = accept ? wcnt_shift + 3'd1 : wcnt_shift;
      flush_in = flush_ff;
      if (accept && req.end_of_document) flush_in = 1'b1;
      if (step_fire && is_last) flush_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         wcnt_ff  <= wcnt_in;
         flush_ff <= flush_in;
      end
      win_ff <= win_in;
   end

   hmt_classifier u_classifier (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_fire),
      .restart     (is_last),
      .unit        (win_ff[0]),
      .la          (la),
      .role        (cls_role),
      .token_start (cls_start)
   );

   // Result register: load on a step, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step_fire) begin
         rsp_unit_ff  <= win_ff[0];
         rsp_role_ff  <= cls_role;
         rsp_start_ff <= cls_start;
         rsp_last_ff  <= is_last;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_unit    = rsp_unit_ff;
   assign rsp.role        = rsp_role_ff;
   assign rsp.token_start = rsp_start_ff;
   assign rsp.last        = rsp_last_ff;

`ifndef SYNTH
   a_wcnt_range: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= 3'd4)
      else $error("window count out of range");

   a_no_accept_in_flush: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req.ready)
      else $error("input accepted during flush");

   a_flush_ends_clean: assert property (@(posedge clock) disable iff (reset)
      (step_fire && is_last) |=> (wcnt_ff == 3'd0 && !flush_ff))
      else $error("window not empty after flush");

   a_markup_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_role_ff == hmt_pkg::ROLE_MARKUP && rsp_start_ff))
      else $error("token start flagged on markup");

   a_step_needs_units: assert property (@(posedge clock) disable iff (reset)
      step_fire |-> (wcnt_ff != 3'd0))
      else $error("step with empty window");
`endif

endmodule
